// ===== hw/rtl/pdf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdf_pkg
// Shared constants, types and codes of the ordered display flush block.
// ----------------------------------------------------------------------------
package pdf_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int PICK_W      = 5;
    localparam int PICK_LIMIT  = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BUF = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NO_DISP   = CFG_IDX_W'(1);

    localparam logic [4:0] FRAME_BUF_RST = 5'd0;
    localparam logic [7:0] NO_DISP_RST   = 8'd254;

    localparam logic       CMD_LOAD  = 1'b0;
    localparam logic       CMD_FLUSH = 1'b1;

    // Running minimum handed from cell to cell
    typedef struct packed {
        logic                    found;
        logic signed [31:0]      poc;
        logic [IDX_W-1:0]        idx;
        logic [7:0]              id;
    } t_cand;

    // Slot clear request from the controller
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } t_clr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_SUM
    } t_state;

endpackage
`default_nettype wire

// ===== hw/rtl/pdf_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdf_in_if
// Command channel: load one slot or run a flush.
// ----------------------------------------------------------------------------
interface pdf_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [3:0]         slot;
    logic               slot_valid;
    logic [7:0]         buffer_id;
    logic signed [31:0] order_count;
    logic [4:0]         pick_count;
    logic signed [31:0] max_order_count;

    modport source (output valid, cmd, slot, slot_valid, buffer_id, order_count,
                    pick_count, max_order_count, input ready);
    modport sink   (input valid, cmd, slot, slot_valid, buffer_id, order_count,
                    pick_count, max_order_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pdf_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdf_out_if
// Result channel: displayed pictures and the closing summary.
// ----------------------------------------------------------------------------
interface pdf_out_if;
    logic               valid;
    logic               ready;
    logic [7:0]         out_buffer_id;
    logic signed [31:0] display_number;
    logic               is_summary;
    logic signed [31:0] new_display_base;
    logic               last;

    modport source (output valid, out_buffer_id, display_number, is_summary,
                    new_display_base, last, input ready);
    modport sink   (input valid, out_buffer_id, display_number, is_summary,
                    new_display_base, last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pdf_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdf_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface pdf_cfg_if;
    import pdf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pdf_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdf_cell
// One table slot; folds its picture into the passing running minimum.
// ----------------------------------------------------------------------------
module pdf_cell
    import pdf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [IDX_W-1:0]   i_idx,
    input  wire logic               i_wr_en,
    input  wire logic               i_wr_used,
    input  wire logic [7:0]         i_wr_id,
    input  wire logic signed [31:0] i_wr_poc,
    input  wire logic               i_clr,
    input  wire t_cand              i_cand,
    output t_cand                   o_cand
);

    logic               r_used;
    logic [7:0]         r_id;
    logic signed [31:0] r_poc;
    t_cand              r_cand;
    t_cand              n_cand;
    logic               w_take;

    // Replace only on strictly smaller POC: earlier slot wins ties
    assign w_take = r_used && (!i_cand.found || (r_poc < i_cand.poc));

    always_comb begin
        n_cand = i_cand;
        if (w_take) begin
            n_cand.found = 1'b1;
            n_cand.poc   = r_poc;
            n_cand.idx   = i_idx;
            n_cand.id    = r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_wr_en) begin
            r_used <= i_wr_used;
        end else if (i_clr) begin
            r_used <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_id  <= i_wr_id;
            r_poc <= i_wr_poc;
        end
        r_cand <= n_cand;
    end

    assign o_cand = r_cand;

endmodule
`default_nettype wire

// ===== hw/rtl/pdf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdf_ctrl
// Flush sequencer, display counters and result register.
// ----------------------------------------------------------------------------
module pdf_ctrl
    import pdf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    pdf_in_if.sink          i_in,
    pdf_out_if.source       o_out,
    input  wire t_cand      i_cand,
    input  wire logic [4:0] i_frame_buf,
    input  wire logic [7:0] i_no_disp,
    output t_clr            o_clr
);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_cnt;
    logic [PICK_W-1:0]  r_picks;
    logic signed [31:0] r_maxpoc;
    logic [31:0]        r_disp;
    logic [31:0]        r_base;
    logic               r_out_valid;
    logic [7:0]         r_out_id;
    logic [31:0]        r_out_num;
    logic               r_out_sum;
    logic [31:0]        r_out_base;

    logic               w_accept;
    logic               w_flush;
    logic               w_out_free;
    logic               w_disp_load;
    logic               w_sum_load;
    logic [31:0]        w_new_base;
    logic [PICK_W-1:0]  w_picks_in;
    t_clr               w_clr;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_flush    = w_accept && (i_in.cmd == CMD_FLUSH);
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_picks_in = (i_in.pick_count > PICK_W'(PICK_LIMIT)) ? PICK_W'(PICK_LIMIT)
                                                                : i_in.pick_count;
    assign w_new_base = r_base + r_maxpoc + 32'(i_frame_buf) + 32'd1;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_flush) begin
                    n_state = (w_picks_in == '0) ? S_SUM : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == IDX_W'(TABLE_SLOTS - 1)) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (!i_cand.found) begin
                    n_state = S_SUM;
                end else if (w_out_free) begin
                    n_state = (r_picks == PICK_W'(1)) ? S_SUM : S_SCAN;
                end
            end
            S_SUM: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        i_in.ready  = 1'b0;
        w_clr.en    = 1'b0;
        w_clr.idx   = i_cand.idx;
        w_disp_load = 1'b0;
        w_sum_load  = 1'b0;
        case (r_state)
            S_IDLE: i_in.ready = 1'b1;
            S_PICK: begin
                w_clr.en    = i_cand.found && w_out_free;
                w_disp_load = w_clr.en && (i_cand.id != i_no_disp);
            end
            S_SUM:  w_sum_load = w_out_free;
            default: ;
        endcase
    end

    assign o_clr = w_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_picks     <= '0;
            r_disp      <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SCAN) begin
                r_cnt <= r_cnt + IDX_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (w_flush) begin
                r_picks <= w_picks_in;
            end else if (w_clr.en) begin
                r_picks <= r_picks - PICK_W'(1);
            end
            if (w_disp_load) begin
                r_disp <= r_disp + 32'd1;
            end
            if (w_sum_load) begin
                r_base <= w_new_base;
            end
            if (w_disp_load || w_sum_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_flush) begin
            r_maxpoc <= i_in.max_order_count;
        end
        if (w_disp_load) begin
            r_out_id   <= i_cand.id;
            r_out_num  <= r_disp + 32'd1;
            r_out_sum  <= 1'b0;
            r_out_base <= '0;
        end else if (w_sum_load) begin
            r_out_id   <= '0;
            r_out_num  <= '0;
            r_out_sum  <= 1'b1;
            r_out_base <= w_new_base;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.out_buffer_id    = r_out_id;
    assign o_out.display_number   = r_out_num;
    assign o_out.is_summary       = r_out_sum;
    assign o_out.new_display_base = r_out_base;
    assign o_out.last             = r_out_sum;

    a_disp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_disp_load |=> r_disp == $past(r_disp) + 32'd1)
        else $error("display counter did not advance on a display pick");

    a_base_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_sum_load |=> $stable(r_base))
        else $error("display base moved outside a summary");

    a_pick_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_picks <= PICK_W'(PICK_LIMIT))
        else $error("pick count above limit");

    a_sum_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sum_load |=> (r_state == S_IDLE) && r_out_valid && r_out_sum)
        else $error("summary did not close the flush");

endmodule
`default_nettype wire

// ===== hw/rtl/poc_ordered_display_flush_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// poc_ordered_display_flush_top
// Picture table with display-order flush: load slots, then bump pictures in
// ascending order count and report the new display base.
// ----------------------------------------------------------------------------
// Flow: a load request writes its slot into one cell register. A flush request
//   scans the table through the cell chain, then takes the minimum as a pick,
//   with a fresh scan before each further pick; the summary comes last.
// Input: the block takes no new request until a flush has put its summary in
//   the result register; an output stall holds the flush longer.
// Reset: all slot valid flags, display counter and display base clear;
//   frame buffering resets to 0 and the do-not-display id to 254.
// ----------------------------------------------------------------------------
module poc_ordered_display_flush_top
    import pdf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pdf_in_if.sink    i_in,
    pdf_out_if.source o_out,
    pdf_cfg_if.sink   i_cfg
);

    logic [4:0] r_frame_buf;
    logic [7:0] r_no_disp;
    logic       w_load;
    t_clr       w_clr;
    t_cand      w_chain [0:TABLE_SLOTS];

    // Configuration: always ready, registers written by index; others drop
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_buf <= FRAME_BUF_RST;
            r_no_disp   <= NO_DISP_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_FRAME_BUF: r_frame_buf <= i_cfg.data[4:0];
                REG_NO_DISP:   r_no_disp   <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // A load request writes the one cell that its slot names
    assign w_load = i_in.valid && i_in.ready && (i_in.cmd == CMD_LOAD);

    // Feed the chain an empty candidate; each cell hands its running minimum
    // to the next, so the chain end holds the full-table minimum once stable
    // contents have passed through the register of every cell.
    assign w_chain[0] = '0;

    for (genvar k = 0; k < TABLE_SLOTS; k++) begin : g_cell
        logic w_wr_en;
        logic w_clr_en;

        assign w_wr_en  = w_load && (32'(i_in.slot) == 32'(k));
        assign w_clr_en = w_clr.en && (w_clr.idx == IDX_W'(k));

        pdf_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_idx     (IDX_W'(k)),
            .i_wr_en   (w_wr_en),
            .i_wr_used (i_in.slot_valid),
            .i_wr_id   (i_in.buffer_id),
            .i_wr_poc  (i_in.order_count),
            .i_clr     (w_clr_en),
            .i_cand    (w_chain[k]),
            .o_cand    (w_chain[k+1])
        );
    end

    // Sequence the picks, count display numbers, hold the result register
    pdf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cand      (w_chain[TABLE_SLOTS]),
        .i_frame_buf (r_frame_buf),
        .i_no_disp   (r_no_disp),
        .o_clr       (w_clr)
    );

endmodule
`default_nettype wire

// ===== tb/tb_poc_ordered_display_flush_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_poc_ordered_display_flush_top
// Self-checking bench for the ordered display flush block. Load and flush
// requests go in over the command channel. A local model of the picture table
// works out the bumped pictures and the summary of every flush. The bench
// compares each result with the oldest pending one while both channels idle
// and stall at random.
// ----------------------------------------------------------------------------
module tb_poc_ordered_display_flush_top;
    import pdf_pkg::*;

    localparam int CLK_HALF      = 5;
    // A load lands in its cell register right after accept. Allow ample slack before touching
    // the registers or ending the run.
    localparam int SETTLE_CYCLES = 2 * TABLE_SLOTS + 8;
    localparam int REPORT_LIMIT  = 10;

    // One request on the command channel
    typedef struct {
        logic               cmd;
        logic [3:0]         slot;
        logic               slot_valid;
        logic [7:0]         buffer_id;
        logic signed [31:0] order_count;
        logic [4:0]         pick_count;
        logic signed [31:0] max_order_count;
    } t_table_req;

    // One result: a displayed picture or the closing summary
    typedef struct {
        logic [7:0]         buffer_id;
        logic signed [31:0] display_number;
        logic               is_summary;
        logic signed [31:0] display_base;
        logic               last;
    } t_bump;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pdf_in_if  in_if ();
    pdf_out_if out_if ();
    pdf_cfg_if cfg_if ();

    poc_ordered_display_flush_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // Local copy of the picture table, the counters and the registers
    // ------------------------------------------------------------------------
    logic               tbl_used [TABLE_SLOTS];
    logic [7:0]         tbl_id   [TABLE_SLOTS];
    logic signed [31:0] tbl_poc  [TABLE_SLOTS];
    logic [31:0]        disp_count;
    logic [31:0]        disp_base;
    logic [4:0]         cur_frame_buf;
    logic [7:0]         cur_no_disp;

    // Pictures and summaries still owed by the block, oldest first
    t_bump              bumped_pictures [$];
    int                 mismatches;
    int                 send_idle_pct;
    int                 recv_stall_pct;

    // Apply one accepted request to the local table. Queue what it must emit.
    function automatic void apply_request(input t_table_req r);
        int    picks;
        int    best;
        t_bump res;
        if (r.cmd == CMD_LOAD) begin
            tbl_used[r.slot] = r.slot_valid;
            tbl_id[r.slot]   = r.buffer_id;
            tbl_poc[r.slot]  = r.order_count;
            return;
        end
        // Clamp oversized pick counts to the table depth
        picks = (r.pick_count > PICK_LIMIT) ? PICK_LIMIT : int'(r.pick_count);
        for (int p = 0; p < picks; p++) begin
            // Find the smallest order count. Strict less keeps the lowest slot on a tie.
            best = -1;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (tbl_used[i] && (best < 0 || tbl_poc[i] < tbl_poc[best]))
                    best = i;
            end
            // Stop early once the table runs dry
            if (best < 0)
                break;
            if (tbl_id[best] != cur_no_disp) begin
                disp_count = disp_count + 32'd1;
                res = '{tbl_id[best], disp_count, 1'b0, 32'sd0, 1'b0};
                bumped_pictures.push_back(res);
            end
            tbl_used[best] = 1'b0;
        end
        disp_base = disp_base + r.max_order_count + 32'(cur_frame_buf) + 32'd1;
        res = '{8'd0, 32'sd0, 1'b1, disp_base, 1'b1};
        bumped_pictures.push_back(res);
    endfunction

    // ------------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------------
    function automatic t_table_req load_req(input logic [3:0] slot, input logic vld,
                                            input logic [7:0] id,
                                            input logic signed [31:0] poc);
        t_table_req r;
        r.cmd             = CMD_LOAD;
        r.slot            = slot;
        r.slot_valid      = vld;
        r.buffer_id       = id;
        r.order_count     = poc;
        r.pick_count      = 5'($urandom);
        r.max_order_count = $signed($urandom);
        return r;
    endfunction

    function automatic t_table_req flush_req(input logic [4:0] picks,
                                             input logic signed [31:0] max_poc);
        t_table_req r;
        r.cmd             = CMD_FLUSH;
        r.slot            = 4'($urandom);
        r.slot_valid      = 1'($urandom);
        r.buffer_id       = 8'($urandom);
        r.order_count     = $signed($urandom);
        r.pick_count      = picks;
        r.max_order_count = max_poc;
        return r;
    endfunction

    // Order counts: small values to force ties, the extremes, or anything
    function automatic logic signed [31:0] rand_poc();
        case ($urandom_range(3))
            0:       return $signed(32'($urandom_range(8))) - 32'sd4;
            1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom);
        endcase
    endfunction

    // Buffer ids hit the do-not-display id often enough to matter
    function automatic logic [7:0] rand_id();
        return ($urandom_range(3) == 0) ? cur_no_disp : 8'($urandom_range(255));
    endfunction

    function automatic logic [4:0] rand_picks();
        case ($urandom_range(9))
            0:       return 5'd0;
            1:       return 5'($urandom_range(31, 17));
            default: return 5'($urandom_range(16, 1));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------
    // Send one request. Idle the channel at random first, then hold valid
    // until the block takes it. Valid stays high on return so that
    // back-to-back requests need no extra edge.
    task automatic send_request(input t_table_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid           <= 1'b1;
        in_if.cmd             <= r.cmd;
        in_if.slot            <= r.slot;
        in_if.slot_valid      <= r.slot_valid;
        in_if.buffer_id       <= r.buffer_id;
        in_if.order_count     <= r.order_count;
        in_if.pick_count      <= r.pick_count;
        in_if.max_order_count <= r.max_order_count;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        apply_request(r);
    endtask

    // Drop the command channel. Wait for every owed result, then let a
    // trailing load finish.
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (bumped_pictures.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers back to back while the block is idle
    task automatic program_registers(input logic [4:0] frame_buf, input logic [7:0] no_disp);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= REG_FRAME_BUF;
        cfg_if.data  <= CFG_DATA_W'(frame_buf);
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cur_frame_buf = frame_buf;
        cfg_if.index <= REG_NO_DISP;
        cfg_if.data  <= no_disp;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cur_no_disp = no_disp;
        cfg_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------------
    // Reset defaults: empty-table flush and the reset do-not-display id
    task automatic test_reset_defaults();
        send_request(flush_req(5'd16, 32'sd0));
        send_request(load_req(4'd0, 1'b1, NO_DISP_RST, 32'sd5));
        send_request(load_req(4'd1, 1'b1, 8'd7, 32'sd5));
        send_request(flush_req(5'd16, -32'sd1));
    endtask

    // Order-count extremes, tie break toward the lowest slot, invalid slots,
    // zero picks, oversized pick counts and a base that wraps
    task automatic test_order_extremes();
        send_request(load_req(4'd15, 1'b1, 8'd255, 32'sh7fffffff));
        send_request(load_req(4'd8, 1'b1, 8'd100, 32'sh80000000));
        send_request(load_req(4'd3, 1'b1, 8'd0, 32'sh80000000));
        send_request(load_req(4'd9, 1'b0, 8'd101, 32'sd0));
        send_request(flush_req(5'd2, 32'sh7fffffff));
        send_request(flush_req(5'd31, 32'sh80000000));
        send_request(flush_req(5'd0, -32'sd1));
        send_request(flush_req(5'd5, 32'sd12345));
    endtask

    // Register extremes: frame buffering 16 and 0, do-not-display ids 0 and 255
    task automatic test_register_settings();
        program_registers(5'd16, 8'd0);
        send_request(load_req(4'd4, 1'b1, 8'd0, 32'sd3));
        send_request(load_req(4'd5, 1'b1, NO_DISP_RST, 32'sd2));
        send_request(load_req(4'd6, 1'b1, 8'd255, 32'sh7fffffff));
        send_request(flush_req(5'd31, 32'sh7fffffff));
        program_registers(5'd0, 8'd255);
        send_request(load_req(4'd2, 1'b1, 8'd255, 32'sd1));
        send_request(flush_req(5'd1, 32'sh80000000));
    endtask

    // Mostly fill-then-flush frames with random content, the rest single
    // stray loads and flushes
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int         sent;
        int         n_loads;
        t_table_req r;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 75) begin
                n_loads = ($urandom_range(3) == 0) ? $urandom_range(16, 8)
                                                   : $urandom_range(6, 1);
                repeat (n_loads) begin
                    r = load_req(4'($urandom_range(15)), $urandom_range(9) != 0,
                                 rand_id(), rand_poc());
                    send_request(r);
                end
                send_request(flush_req(rand_picks(), rand_poc()));
                sent += n_loads + 1;
            end else begin
                if ($urandom_range(1))
                    r = load_req(4'($urandom), 1'($urandom), 8'($urandom), $signed($urandom));
                else
                    r = flush_req(5'($urandom), $signed($urandom));
                send_request(r);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall on ready, compare each accepted result
    // ------------------------------------------------------------------------
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_if.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        t_bump want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (bumped_pictures.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $write("%0t unexpected result: id=%0d num=%0d ",
                           $realtime, out_if.out_buffer_id, out_if.display_number);
                    $display("summ=%0b base=%0d last=%0b",
                             out_if.is_summary, out_if.new_display_base, out_if.last);
                end
            end else begin
                want = bumped_pictures.pop_front();
                if (out_if.out_buffer_id    !== want.buffer_id      ||
                    out_if.display_number   !== want.display_number ||
                    out_if.is_summary       !== want.is_summary     ||
                    out_if.new_display_base !== want.display_base   ||
                    out_if.last             !== want.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $write("%0t bad result: expected id=%0d num=%0d ",
                               $realtime, want.buffer_id, want.display_number);
                        $display("summ=%0b base=%0d last=%0b",
                                 want.is_summary, want.display_base, want.last);
                        $write("%0t               actual id=%0d num=%0d ",
                               $realtime, out_if.out_buffer_id, out_if.display_number);
                        $display("summ=%0b base=%0d last=%0b",
                                 out_if.is_summary, out_if.new_display_base, out_if.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------------
    initial begin
        // Drive every block input to a known value before the first edge
        in_if.valid           <= 1'b0;
        in_if.cmd             <= CMD_LOAD;
        in_if.slot            <= '0;
        in_if.slot_valid      <= 1'b0;
        in_if.buffer_id       <= '0;
        in_if.order_count     <= '0;
        in_if.pick_count      <= '0;
        in_if.max_order_count <= '0;
        cfg_if.valid          <= 1'b0;
        cfg_if.index          <= REG_FRAME_BUF;
        cfg_if.data           <= '0;

        // Local model starts from the reset state
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            tbl_used[i] = 1'b0;
            tbl_id[i]   = '0;
            tbl_poc[i]  = '0;
        end
        disp_count     = '0;
        disp_base      = '0;
        cur_frame_buf  = FRAME_BUF_RST;
        cur_no_disp    = NO_DISP_RST;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // Hold reset, then release for good
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_order_extremes();
        test_register_settings();

        // Random phases: no idling, idle sender, stalling receiver, then both
        program_registers(5'd16, 8'd0);
        test_random_traffic(70, 0, 0);
        program_registers(5'd0, 8'd255);
        test_random_traffic(70, 56, 0);
        program_registers(5'($urandom_range(16)), 8'($urandom_range(255)));
        test_random_traffic(70, 0, 56);
        program_registers(5'($urandom_range(16)), 8'($urandom_range(255)));
        test_random_traffic(70, 16, 16);

        // Drain, then watch a while longer for stray results
        wait_idle();
        if (mismatches == 0) begin
            $display("poc_ordered_display_flush_top: match");
        end else begin
            $display("poc_ordered_display_flush_top: mismatch");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #5_000_000;
        $display("poc_ordered_display_flush_top: mismatch");
        $finish;
    end

endmodule
